// ===== sv/atrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// atrlp_pkg
// Shared types, codes, character constants and token tables for the modem
// response line parser.
// ----------------------------------------------------------------------------
package atrlp_pkg;

  localparam int unsigned NUMBER_WIDTH_DEF = 16;

  localparam logic [15:0] MAX_LENGTH_RST    = 16'd118;
  localparam logic [7:0]  CHANNEL_LIMIT_RST = 8'd4;

  // configuration register indexes
  localparam logic CFG_MAX_LENGTH    = 1'b0;
  localparam logic CFG_CHANNEL_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    PS_IDLE   = 4'd0,
    PS_ERR    = 4'd1,
    PS_NL     = 4'd2,
    PS_STATUS = 4'd3,
    PS_TAG    = 4'd4,
    PS_CHN    = 4'd5,
    PS_LEN    = 4'd6,
    PS_DATA   = 4'd7,
    PS_BREAK  = 4'd8,
    PS_TRAIL  = 4'd9,
    PS_PROMPT = 4'd10
  } parse_state_e;

  typedef enum logic [1:0] {
    EV_STATUS  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_DONE    = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    STS_SUCCESS   = 2'd0,
    STS_ERROR     = 2'd1,
    STS_NO_CHANGE = 2'd2,
    STS_INPUT     = 2'd3
  } status_code_e;

  typedef enum logic [1:0] {
    TOK_OK        = 2'd0,
    TOK_SEND_OK   = 2'd1,
    TOK_NO_CHANGE = 2'd2,
    TOK_IPD       = 2'd3
  } token_e;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_GT    = 8'h3e;

  localparam logic [15:0] WORD_OK = 16'h4f4b;

  typedef struct packed {
    event_kind_e  kind;
    status_code_e status;
    logic [7:0]   channel;
    logic [15:0]  length;
    logic [7:0]   payload_byte;
    logic [15:0]  payload_index;
  } result_t;

  // token text, right aligned, first character highest
  function automatic logic [71:0] tok_text(input token_e tok);
    logic [71:0] txt;
    txt = '0;
    case (tok)
      TOK_OK:        txt = 72'("OK");
      TOK_SEND_OK:   txt = 72'("SEND OK");
      TOK_NO_CHANGE: txt = 72'("no change");
      TOK_IPD:       txt = 72'("IPD");
      default:       txt = '0;
    endcase
    return txt;
  endfunction

  function automatic logic [3:0] tok_len(input token_e tok);
    logic [3:0] len;
    len = '0;
    case (tok)
      TOK_OK:        len = 4'd2;
      TOK_SEND_OK:   len = 4'd7;
      TOK_NO_CHANGE: len = 4'd9;
      TOK_IPD:       len = 4'd3;
      default:       len = '0;
    endcase
    return len;
  endfunction

  // true when character c matches the token at position pos
  function automatic logic tok_char_ok(input token_e tok, input logic [3:0] pos,
                                       input logic [7:0] c);
    logic [71:0] txt;
    logic [3:0]  len;
    logic [3:0]  rev;
    logic [7:0]  ch;
    logic        hit;
    txt = tok_text(tok);
    len = tok_len(tok);
    rev = len - 4'd1 - pos;
    ch  = '0;
    hit = 1'b0;
    if (pos < len) begin
      ch  = txt[{rev, 3'b000} +: 8];
      hit = (c == ch);
    end
    return hit;
  endfunction

endpackage

// ===== sv/at_response_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// at_response_line_parser_unit
// Modem response line parser: status lines, input prompt and +IPD frames.
// ----------------------------------------------------------------------------
// Each received byte is a transfer on the input channel; it gives at most one
// result transfer (status or prompt, payload byte, or message complete). A
// byte waits in the input register until the parser takes it; at that edge the
// parser state is updated and any result is written to the output register,
// so a result is offered on the output the cycle after its byte is taken. The
// parser updates its state once per cycle in one pass over a single byte, so
// one byte is taken every cycle while the output side keeps taking results.
// Configuration writes take effect on the next byte and are meant for times
// when no byte is in flight.
module at_response_line_parser_unit
  import atrlp_pkg::*;
#(
  parameter int unsigned NumberWidth = NUMBER_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [1:0]  status_code_o,
  output logic [7:0]  channel_o,
  output logic [15:0] length_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] max_length_q;
  logic [7:0]  channel_limit_q;
  logic        byte_valid;
  logic [7:0]  cur_byte;
  logic        out_space;
  logic        advance;
  logic        res_valid;
  result_t     res;
  result_t     res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q    <= MAX_LENGTH_RST;
      channel_limit_q <= CHANNEL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_LENGTH:    max_length_q    <= cfg_wdata_i;
        CFG_CHANNEL_LIMIT: channel_limit_q <= cfg_wdata_i[7:0];
        default:           max_length_q    <= max_length_q;
      endcase
    end
  end

  assign advance = byte_valid && out_space;

  atrlp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (advance),
    .byte_valid_o (byte_valid),
    .byte_o       (cur_byte)
  );

  atrlp_parser #(
    .NumberWidth (NumberWidth)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .c_i             (cur_byte),
    .max_length_i    (max_length_q),
    .channel_limit_i (channel_limit_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  atrlp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign event_kind_o    = res_out.kind;
  assign status_code_o   = res_out.status;
  assign channel_o       = res_out.channel;
  assign length_o        = res_out.length;
  assign payload_byte_o  = res_out.payload_byte;
  assign payload_index_o = res_out.payload_index;

endmodule

// ===== sv/atrlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// atrlp_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module atrlp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       in_xfer;

  assign in_ready_o = !valid_q || advance_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_xfer) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

// ===== sv/atrlp_parser.sv =====
// ----------------------------------------------------------------------------
// atrlp_parser
// Line parser state and per-byte update: token matching, decimal
// accumulation, payload counting and result formation.
// ----------------------------------------------------------------------------
module atrlp_parser
  import atrlp_pkg::*;
#(
  parameter int unsigned NumberWidth = NUMBER_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic [7:0]  c_i,
  input  logic [15:0] max_length_i,
  input  logic [7:0]  channel_limit_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam int unsigned CmpWidth = (NumberWidth > 16) ? NumberWidth : 16;

  parse_state_e           state_q, state_d;
  logic [NumberWidth-1:0] acc_q, acc_d;
  logic [7:0]             chn_q, chn_d;
  logic [15:0]            len_q, len_d;
  logic [15:0]            cnt_q, cnt_d;
  logic [3:0]             pos_q, pos_d;
  logic [3:0]             flags_q, flags_d;
  logic [15:0]            last_q, last_d;

  logic [3:0]             flags_kept;
  logic [3:0]             pos_inc;
  logic [3:0]             tok_hit;
  logic                   is_digit;
  logic [NumberWidth-1:0] acc_mul;
  logic [CmpWidth-1:0]    acc_cmp;
  logic [CmpWidth-1:0]    max_cmp;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      flags_kept[i] = flags_q[i] && tok_char_ok(token_e'(i), pos_q, c_i);
      tok_hit[i]    = flags_q[i] && (pos_q == tok_len(token_e'(i)));
    end
  end

  assign pos_inc  = (pos_q == 4'd15) ? pos_q : pos_q + 4'd1;
  assign is_digit = (c_i >= CH_ZERO) && (c_i <= CH_NINE);
  assign acc_mul  = (acc_q << 3) + (acc_q << 1) + NumberWidth'(c_i - CH_ZERO);
  assign acc_cmp  = CmpWidth'(acc_q);
  assign max_cmp  = CmpWidth'(max_length_i);

  // next state
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    chn_d       = chn_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    flags_d     = flags_q;
    last_d      = {last_q[7:0], c_i};
    case (state_q)
      PS_ERR: begin
        if (c_i == CH_LF) state_d = PS_IDLE;
        pos_d = '0; flags_d = '1; acc_d = '0;
      end
      PS_NL: begin
        if (c_i == CH_LF || c_i == CH_CR) begin
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else if (c_i == CH_PLUS) begin
          state_d = PS_TAG;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else if (c_i == CH_GT) begin
          state_d = PS_PROMPT;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else begin
          // first character of a status line
          state_d = PS_STATUS;
          flags_d = flags_kept;
          pos_d   = pos_inc;
        end
      end
      PS_STATUS: begin
        if (c_i == CH_CR) begin
          state_d = PS_ERR;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else begin
          flags_d = flags_kept;
          pos_d   = pos_inc;
        end
      end
      PS_TAG: begin
        if (c_i == CH_COMMA) begin
          state_d = tok_hit[TOK_IPD] ? PS_CHN : PS_ERR;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else if (c_i == CH_COLON) begin
          state_d = PS_ERR;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else begin
          flags_d = flags_kept;
          pos_d   = pos_inc;
        end
      end
      PS_CHN: begin
        if (c_i == CH_COMMA) begin
          chn_d   = acc_q[7:0];
          state_d = (acc_q[7:0] >= channel_limit_i) ? PS_ERR : PS_LEN;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else if (!is_digit) begin
          state_d = PS_ERR;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else begin
          acc_d   = acc_mul;
          flags_d = flags_kept;
          pos_d   = pos_inc;
        end
      end
      PS_LEN: begin
        if (c_i == CH_COLON) begin
          len_d   = 16'(acc_q);
          cnt_d   = '0;
          state_d = (acc_cmp >= max_cmp) ? PS_ERR : PS_DATA;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else if (!is_digit) begin
          state_d = PS_ERR;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end else begin
          acc_d   = acc_mul;
          flags_d = flags_kept;
          pos_d   = pos_inc;
        end
      end
      PS_DATA: begin
        if (cnt_q >= len_q) begin
          state_d = (c_i == CH_CR) ? PS_BREAK : PS_ERR;
        end
        cnt_d = cnt_q + 16'd1;
      end
      PS_BREAK: begin
        // a trailing line never opens with a carriage return
        if (c_i != CH_CR && c_i != CH_LF) state_d = PS_TRAIL;
      end
      PS_TRAIL: begin
        if (c_i == CH_CR) begin
          state_d = PS_ERR;
          pos_d = '0; flags_d = '1; acc_d = '0;
        end
      end
      PS_PROMPT: begin
        if (c_i == CH_SPACE) begin
          state_d = PS_IDLE;
        end else begin
          state_d = PS_ERR;
        end
        pos_d = '0; flags_d = '1; acc_d = '0;
      end
      default: begin
        state_d = (c_i == CH_CR || c_i == CH_LF) ? PS_NL : PS_ERR;
        pos_d = '0; flags_d = '1; acc_d = '0;
      end
    endcase
  end

  // result formation
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_q)
      PS_STATUS: begin
        if (c_i == CH_CR) begin
          res_valid_o = 1'b1;
          res_o.kind  = EV_STATUS;
          if (tok_hit[TOK_OK] || tok_hit[TOK_SEND_OK]) begin
            res_o.status = STS_SUCCESS;
          end else if (tok_hit[TOK_NO_CHANGE]) begin
            res_o.status = STS_NO_CHANGE;
          end else begin
            res_o.status = STS_ERROR;
          end
        end
      end
      PS_DATA: begin
        if (cnt_q < len_q) begin
          res_valid_o         = 1'b1;
          res_o.kind          = EV_PAYLOAD;
          res_o.status        = STS_SUCCESS;
          res_o.channel       = chn_q;
          res_o.length        = len_q;
          res_o.payload_byte  = c_i;
          res_o.payload_index = cnt_q;
        end
      end
      PS_TRAIL: begin
        if (c_i == CH_CR) begin
          res_valid_o   = 1'b1;
          res_o.kind    = EV_DONE;
          res_o.status  = (last_q == WORD_OK) ? STS_SUCCESS : STS_ERROR;
          res_o.channel = chn_q;
          res_o.length  = len_q;
        end
      end
      PS_PROMPT: begin
        if (c_i == CH_SPACE) begin
          res_valid_o  = 1'b1;
          res_o.kind   = EV_STATUS;
          res_o.status = STS_INPUT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_IDLE;
      acc_q   <= '0;
      chn_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      flags_q <= '1;
      last_q  <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
      acc_q   <= acc_d;
      chn_q   <= chn_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== sv/atrlp_out_stage.sv =====
// ----------------------------------------------------------------------------
// atrlp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module atrlp_out_stage
  import atrlp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== verif/atrlp_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// atrlp_tb_pkg
// Scoreboard for the modem response line parser testbench.
// ----------------------------------------------------------------------------
// Holds a private copy of the parser state and of both limit registers. Each
// accepted byte is run through that copy, and any event it gives is queued.
// Every result transfer is compared field by field with the oldest queued
// event.
// ----------------------------------------------------------------------------
package atrlp_tb_pkg;
  import atrlp_pkg::*;

  class parser_event_board;
    result_t      awaited_events[$];
    int unsigned  failures;
    int unsigned  reports;
    logic [15:0]  max_length;
    logic [7:0]   channel_limit;
    parse_state_e state;
    logic [15:0]  number;
    logic [7:0]   channel;
    logic [15:0]  length;
    logic [15:0]  data_count;
    logic [3:0]   tok_pos;
    logic [3:0]   tok_live;
    logic [15:0]  last_two;
    string        tok_words[4];

    function new();
      tok_words     = '{"OK", "SEND OK", "no change", "IPD"};
      failures      = 0;
      reports       = 0;
      max_length    = MAX_LENGTH_RST;
      channel_limit = CHANNEL_LIMIT_RST;
      state         = PS_IDLE;
      number        = '0;
      channel       = '0;
      length        = '0;
      data_count    = '0;
      tok_pos       = '0;
      tok_live      = '1;
      last_two      = '0;
    endfunction

    function void set_reg(input logic idx, input logic [15:0] val);
      if (idx == CFG_MAX_LENGTH) max_length = val;
      else channel_limit = val[7:0];
    endfunction

    function void restart_token();
      tok_pos  = '0;
      tok_live = '1;
      number   = '0;
    endfunction

    function void take_char(input logic [7:0] c);
      for (int i = 0; i < 4; i++) begin
        if (tok_pos >= tok_words[i].len() || c != tok_words[i][tok_pos]) tok_live[i] = 1'b0;
      end
      if (tok_pos != 4'd15) tok_pos = tok_pos + 4'd1;
    endfunction

    function bit token_hit(input token_e tok);
      return tok_live[tok] && (tok_pos == tok_words[tok].len());
    endfunction

    function void queue_event(input event_kind_e kind, input status_code_e code,
                              input logic [7:0] ch, input logic [15:0] len,
                              input logic [7:0] data, input logic [15:0] idx);
      result_t ev;
      ev.kind          = kind;
      ev.status        = code;
      ev.channel       = ch;
      ev.length        = len;
      ev.payload_byte  = data;
      ev.payload_index = idx;
      awaited_events.push_back(ev);
    endfunction

    // advance the parser copy by one accepted byte
    function void note_byte(input logic [7:0] c);
      bit           again;
      status_code_e code;
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (state)
          PS_ERR: begin
            if (c == CH_LF) state = PS_IDLE;
            restart_token();
          end
          PS_NL: begin
            if (c == CH_LF || c == CH_CR) begin
              restart_token();
            end else if (c == CH_PLUS) begin
              state = PS_TAG;
              restart_token();
            end else if (c == CH_GT) begin
              state = PS_PROMPT;
              restart_token();
            end else begin
              state = PS_STATUS;
              again = 1'b1;
            end
          end
          PS_STATUS: begin
            if (c == CH_CR) begin
              if (token_hit(TOK_OK) || token_hit(TOK_SEND_OK)) code = STS_SUCCESS;
              else if (token_hit(TOK_NO_CHANGE)) code = STS_NO_CHANGE;
              else code = STS_ERROR;
              queue_event(EV_STATUS, code, '0, '0, '0, '0);
              state = PS_ERR;
              restart_token();
            end else begin
              take_char(c);
            end
          end
          PS_TAG: begin
            if (c == CH_COMMA) begin
              state = token_hit(TOK_IPD) ? PS_CHN : PS_ERR;
              restart_token();
            end else if (c == CH_COLON) begin
              state = PS_ERR;
              restart_token();
            end else begin
              take_char(c);
            end
          end
          PS_CHN, PS_LEN: begin
            if (state == PS_CHN && c == CH_COMMA) begin
              channel = number[7:0];
              state   = (channel >= channel_limit) ? PS_ERR : PS_LEN;
              restart_token();
            end else if (state == PS_LEN && c == CH_COLON) begin
              length     = number;
              data_count = '0;
              state      = (number >= max_length) ? PS_ERR : PS_DATA;
              restart_token();
            end else if (c < CH_ZERO || c > CH_NINE) begin
              state = PS_ERR;
              restart_token();
            end else begin
              number = 16'(number * 16'd10 + 16'(c - CH_ZERO));
              take_char(c);
            end
          end
          PS_DATA: begin
            if (data_count >= length) state = (c == CH_CR) ? PS_BREAK : PS_ERR;
            else queue_event(EV_PAYLOAD, STS_SUCCESS, channel, length, c, data_count);
            data_count = data_count + 16'd1;
          end
          PS_BREAK: begin
            if (c != CH_CR && c != CH_LF) begin
              state = PS_TRAIL;
              again = 1'b1;
            end
          end
          PS_TRAIL: begin
            if (c == CH_CR) begin
              code = (last_two == 16'("OK")) ? STS_SUCCESS : STS_ERROR;
              queue_event(EV_DONE, code, channel, length, '0, '0);
              state = PS_ERR;
              restart_token();
            end
          end
          PS_PROMPT: begin
            if (c == CH_SPACE) begin
              queue_event(EV_STATUS, STS_INPUT, '0, '0, '0, '0);
              state = PS_IDLE;
            end else begin
              state = PS_ERR;
            end
            restart_token();
          end
          default: begin
            state = (c == CH_CR || c == CH_LF) ? PS_NL : PS_ERR;
            restart_token();
          end
        endcase
      end
      last_two = {last_two[7:0], c};
    endfunction

    function void check_event(input result_t got);
      result_t want;
      if (awaited_events.size() == 0) begin
        failures++;
        reports++;
        if (reports <= 10)
          $display("unexpected result: kind %0d status %0d channel %0d length %0d",
                   got.kind, got.status, got.channel, got.length);
        return;
      end
      want = awaited_events.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.channel !== want.channel || got.length !== want.length ||
          got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index) begin
        failures++;
        reports++;
        if (reports <= 10) begin
          $display("mismatch: expected kind %0d status %0d ch %0d len %0d byte %0h idx %0d",
                   want.kind, want.status, want.channel, want.length,
                   want.payload_byte, want.payload_index);
          $display("          got      kind %0d status %0d ch %0d len %0d byte %0h idx %0d",
                   got.kind, got.status, got.channel, got.length,
                   got.payload_byte, got.payload_index);
        end
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_at_response_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tb_at_response_line_parser_unit
// Testbench for the modem response line parser.
// ----------------------------------------------------------------------------
// A short directed stream covers a status line, the input prompt and a frame
// with its payload and trailing line. Random phases then send mostly well
// formed status lines, prompts and +IPD frames with random content, mixed with
// noise and corrupted bytes, under several limit settings. Both handshakes
// idle in random bursts except in the final phase. Every result transfer is
// checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb_at_response_line_parser_unit;
  import atrlp_pkg::*;
  import atrlp_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  event_kind;
  logic [1:0]  status_code;
  logic [7:0]  channel;
  logic [15:0] length;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;

  parser_event_board board;
  logic [7:0]        byte_plan[$];
  bit                gaps_on;
  bit                stall_on;
  int unsigned       stall_left;
  int unsigned       cycle_count;
  int unsigned       cur_max_len;
  int unsigned       cur_ch_limit;
  result_t           seen_event;

  at_response_line_parser_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .event_kind_o    (event_kind),
    .status_code_o   (status_code),
    .channel_o       (channel),
    .length_o        (length),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #4 clk = ~clk;

  // result side: check transfers and stall in bursts
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[at_response_line_parser_unit] ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_event.kind          = event_kind_e'(event_kind);
        seen_event.status        = status_code_e'(status_code);
        seen_event.channel       = channel;
        seen_event.length        = length;
        seen_event.payload_byte  = payload_byte;
        seen_event.payload_index = payload_index;
        board.check_event(seen_event);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= (stall_left == 0);
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b);
  endtask

  task automatic send_plan();
    while (byte_plan.size() != 0) push_byte(byte_plan.pop_front());
  endtask

  task automatic settle();
    while (board.awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_plan.push_back(s[i]);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) byte_plan.push_back(8'($urandom));
  endtask

  task automatic add_line_end();
    byte_plan.push_back(CH_CR);
    byte_plan.push_back(CH_LF);
  endtask

  task automatic add_number(input int unsigned v);
    if ($urandom_range(0, 7) == 0) add_text("00");
    add_text($sformatf("%0d", v));
  endtask

  task automatic plan_frame();
    int unsigned r;
    int unsigned ch_val;
    int unsigned len_val;
    int unsigned count;
    add_line_end();
    byte_plan.push_back(CH_PLUS);
    case ($urandom_range(0, 19))
      0:       add_text("IPX");
      1:       add_text("IP");
      2:       add_text("IPDD");
      3:       add_text("IP:D");
      4:       ;
      default: add_text("IPD");
    endcase
    byte_plan.push_back(CH_COMMA);
    r = $urandom_range(0, 19);
    if (r == 0) ch_val = $urandom_range(256, 300);
    else if (r == 1) ch_val = cur_ch_limit + $urandom_range(0, 2);
    else if (cur_ch_limit == 0) ch_val = 0;
    else ch_val = $urandom_range(0, cur_ch_limit - 1);
    // an empty channel number reads as zero
    if (r != 2) add_number(ch_val);
    byte_plan.push_back(CH_COMMA);
    r = $urandom_range(0, 15);
    if (r == 0) len_val = 65536 + $urandom_range(0, 9);
    else if (r == 1) len_val = cur_max_len + $urandom_range(0, 3);
    else if (cur_max_len == 0) len_val = 0;
    else len_val = $urandom_range(0, (cur_max_len - 1 < 24) ? cur_max_len - 1 : 24);
    if (r == 2) add_text("1x");
    else add_number(len_val);
    byte_plan.push_back(CH_COLON);
    count = (len_val < 64) ? len_val : $urandom_range(0, 8);
    r = $urandom_range(0, 9);
    if (r == 0) count++;
    else if (r == 1 && count != 0) count--;
    add_random(count);
    add_line_end();
    case ($urandom_range(0, 6))
      0, 1, 2: add_text("OK");
      3:       add_text("ERROR");
      4:       add_text("SEND OK");
      5:       add_random($urandom_range(1, 4));
      default: ;
    endcase
    add_line_end();
  endtask

  task automatic plan_status();
    add_line_end();
    case ($urandom_range(0, 8))
      0:       add_text("OK");
      1:       add_text("SEND OK");
      2:       add_text("no change");
      3:       add_text("ERROR");
      4:       add_text("O");
      5:       add_text("SEND OK SEND OK OK");
      6:       add_text("no chang");
      7:       add_text("OKK");
      default: add_random($urandom_range(1, 5));
    endcase
    add_line_end();
  endtask

  task automatic plan_prompt();
    add_line_end();
    byte_plan.push_back(CH_GT);
    if ($urandom_range(0, 4) == 0) add_random(1);
    else byte_plan.push_back(CH_SPACE);
  endtask

  task automatic plan_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) plan_frame();
    else if (pick < 8) plan_status();
    else if (pick < 9) plan_prompt();
    else add_random($urandom_range(1, 6));
    if ($urandom_range(0, 14) == 0)
      byte_plan[$urandom_range(0, byte_plan.size() - 1)] = 8'($urandom);
  endtask

  task automatic run_phase(input logic [15:0] max_len, input logic [7:0] lim,
                           input int unsigned n_bytes, input bit idle);
    int unsigned sent;
    sent = 0;
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAX_LENGTH;
    cfg_wdata <= max_len;
    @(posedge clk);
    board.set_reg(CFG_MAX_LENGTH, max_len);
    cfg_idx   <= CFG_CHANNEL_LIMIT;
    cfg_wdata <= {8'h00, lim};
    @(posedge clk);
    board.set_reg(CFG_CHANNEL_LIMIT, {8'h00, lim});
    cfg_we <= 1'b0;
    cur_max_len  = max_len;
    cur_ch_limit = lim;
    while (sent < n_bytes) begin
      gaps_on  = idle && ($urandom_range(0, 2) != 0);
      stall_on = idle && ($urandom_range(0, 2) != 0);
      plan_sequence();
      sent += byte_plan.size();
      send_plan();
    end
    in_valid <= 1'b0;
    settle();
  endtask

  initial begin
    board        = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    rx_byte      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_MAX_LENGTH;
    cfg_wdata    = '0;
    gaps_on      = 1'b0;
    stall_on     = 1'b0;
    stall_left   = 0;
    cycle_count  = 0;
    cur_max_len  = MAX_LENGTH_RST;
    cur_ch_limit = CHANNEL_LIMIT_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // status line, input prompt, then a frame with extreme payload bytes
    add_line_end();
    add_text("OK");
    add_line_end();
    byte_plan.push_back(CH_CR);
    byte_plan.push_back(CH_GT);
    byte_plan.push_back(CH_SPACE);
    byte_plan.push_back(CH_LF);
    add_text("+IPD,3,2:");
    byte_plan.push_back(8'h00);
    byte_plan.push_back(8'hff);
    byte_plan.push_back(CH_CR);
    add_text("OK");
    byte_plan.push_back(CH_CR);
    send_plan();
    in_valid <= 1'b0;
    settle();

    run_phase(16'hffff, 8'hff, 300, 1'b1);
    run_phase(16'd0,    8'd1,  150, 1'b1);
    run_phase(16'd200,  8'd0,  100, 1'b1);
    run_phase(16'd40,   8'd17, 300, 1'b1);
    run_phase(16'd118,  8'd4,  300, 1'b1);
    run_phase(16'd9000, 8'd2,  250, 1'b0);

    if (board.failures == 0 && board.awaited_events.size() == 0) begin
      $display("[at_response_line_parser_unit] OK");
    end else begin
      $display("[at_response_line_parser_unit] ERROR");
    end
    $finish;
  end

endmodule
